[hdl/cfe_pkg.sv]
`default_nettype none

package cfe_pkg;

	// queue between the intake side and the frame sequencer
	localparam int CFE_QUEUE_DEPTH = 4;

	// configuration port
	localparam int CFE_ADDR_W = 2;
	localparam logic [CFE_ADDR_W-1:0] CFE_REG_APPEND_RETURN = 2'd0;

	// frame bytes
	localparam logic [7:0] CFE_DELIM = 8'h2B;
	localparam logic [7:0] CFE_CR = 8'h0D;

	// crc-16/ccitt-false
	localparam logic [15:0] CFE_CRC_POLY = 16'h1021;
	localparam logic [15:0] CFE_CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CFE_CRC_TOP = 16'h8000;

	// one queued payload byte with its framing marks
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [31:0] length;
	} cfe_entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} cfe_q_stat_t;

	// one byte through the crc, msb first
	function automatic logic [15:0] cfe_crc_byte(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CFE_CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CFE_CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[hdl/cfe_in_if.sv]
`default_nettype none

interface cfe_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        first_byte;
	logic        last_byte;
	logic [31:0] payload_length;

	modport source (output valid, output payload_byte, output first_byte,
		output last_byte, output payload_length, input ready);
	modport sink (input valid, input payload_byte, input first_byte,
		input last_byte, input payload_length, output ready);
endinterface

`default_nettype wire

[hdl/cfe_out_if.sv]
`default_nettype none

interface cfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;

	modport source (output valid, output out_byte, output frame_end, input ready);
	modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

`default_nettype wire

[hdl/cfe_front.sv]
`default_nettype none

module cfe_front (
	input  wire                  clk,
	input  wire                  arst_n,
	cfe_in_if.sink               in_ch,
	input  cfe_pkg::cfe_q_stat_t stat,
	output logic                 push,
	output cfe_pkg::cfe_entry_t  push_entry
);
	import cfe_pkg::*;

	logic in_frame_q;
	logic take;

	// accept whenever the queue has room; stray bytes are taken and dropped
	assign in_ch.ready = !stat.full;
	assign take = in_ch.valid && in_ch.ready;
	assign push = take && (in_ch.first_byte || in_frame_q);

	always_comb begin
		push_entry.data = in_ch.payload_byte;
		push_entry.first = in_ch.first_byte;
		push_entry.last = in_ch.last_byte;
		push_entry.length = in_ch.payload_length;
	end

	// open frame tracking at intake time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (take) begin
			if (in_ch.first_byte) begin
				in_frame_q <= !in_ch.last_byte;
			end else if (in_ch.last_byte) begin
				in_frame_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/cfe_queue.sv]
`default_nettype none

module cfe_queue #(
	parameter int DEPTH = cfe_pkg::CFE_QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  cfe_pkg::cfe_entry_t  push_entry,
	input  wire                  pop,
	output cfe_pkg::cfe_entry_t  head,
	output cfe_pkg::cfe_q_stat_t stat
);
	import cfe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cfe_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/cfe_back.sv]
`default_nettype none

module cfe_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cfe_pkg::cfe_entry_t  head,
	input  cfe_pkg::cfe_q_stat_t stat,
	input  wire                  append_return,
	output logic                 pop,
	cfe_out_if.source            out_ch
);
	import cfe_pkg::*;

	// sequencer phases, one output byte each
	localparam logic [3:0] PH_D0   = 4'd0;
	localparam logic [3:0] PH_D1   = 4'd1;
	localparam logic [3:0] PH_D2   = 4'd2;
	localparam logic [3:0] PH_L3   = 4'd3;
	localparam logic [3:0] PH_L2   = 4'd4;
	localparam logic [3:0] PH_L1   = 4'd5;
	localparam logic [3:0] PH_L0   = 4'd6;
	localparam logic [3:0] PH_DATA = 4'd7;
	localparam logic [3:0] PH_CH   = 4'd8;
	localparam logic [3:0] PH_CL   = 4'd9;
	localparam logic [3:0] PH_T0   = 4'd10;
	localparam logic [3:0] PH_T1   = 4'd11;
	localparam logic [3:0] PH_T2   = 4'd12;
	localparam logic [3:0] PH_CR   = 4'd13;

	logic [3:0]  phase_q;
	logic        started_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        frame_end_q;

	logic [3:0]  cur_phase;
	logic [3:0]  next_phase;
	logic        done;
	logic        advance;
	logic [7:0]  byte_n;
	logic        end_n;
	logic        crc_load;
	logic [15:0] crc_base;
	logic [15:0] crc_next;

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.frame_end = frame_end_q;

	// a fresh entry starts at the header or straight at its data byte
	assign cur_phase = started_q ? phase_q : (head.first ? PH_D0 : PH_DATA);
	assign advance = !stat.empty && (!out_valid_q || out_ch.ready);
	assign pop = advance && done;

	// byte selection and phase stepping
	always_comb begin
		byte_n = CFE_DELIM;
		end_n = 1'b0;
		next_phase = cur_phase;
		done = 1'b0;
		crc_load = 1'b0;
		unique case (cur_phase)
			PH_D0: next_phase = PH_D1;
			PH_D1: next_phase = PH_D2;
			PH_D2: next_phase = PH_L3;
			PH_L3: begin
				byte_n = head.length[31:24];
				crc_load = 1'b1;
				next_phase = PH_L2;
			end
			PH_L2: begin
				byte_n = head.length[23:16];
				crc_load = 1'b1;
				next_phase = PH_L1;
			end
			PH_L1: begin
				byte_n = head.length[15:8];
				crc_load = 1'b1;
				next_phase = PH_L0;
			end
			PH_L0: begin
				byte_n = head.length[7:0];
				crc_load = 1'b1;
				next_phase = PH_DATA;
			end
			PH_DATA: begin
				byte_n = head.data;
				crc_load = 1'b1;
				next_phase = PH_CH;
				done = !head.last;
			end
			PH_CH: begin
				byte_n = crc_q[15:8];
				next_phase = PH_CL;
			end
			PH_CL: begin
				byte_n = crc_q[7:0];
				next_phase = PH_T0;
			end
			PH_T0: next_phase = PH_T1;
			PH_T1: next_phase = PH_T2;
			PH_T2: begin
				end_n = !append_return;
				next_phase = PH_CR;
				done = !append_return;
			end
			PH_CR: begin
				byte_n = CFE_CR;
				end_n = 1'b1;
				done = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// crc restarts with the first length byte of a frame
	assign crc_base = (cur_phase == PH_L3) ? CFE_CRC_INIT : crc_q;
	assign crc_next = cfe_crc_byte(crc_base, byte_n);

	// sequencer and crc state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_D0;
			started_q <= 1'b0;
			crc_q <= CFE_CRC_INIT;
		end else if (advance) begin
			phase_q <= next_phase;
			started_q <= !done;
			if (crc_load) begin
				crc_q <= crc_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_n;
			frame_end_q <= end_n;
		end
	end

	// a frame only ends on the closing delimiter or the carriage return
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_end_q) |-> (out_byte_q == CFE_DELIM || out_byte_q == CFE_CR))
		else $error("frame end on a byte that cannot close a frame");

	// an entry in progress stays at the queue head until it is done
	assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> !stat.empty)
		else $error("sequencer mid entry with an empty queue");

	// the crc is only touched on length and data bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (cur_phase == PH_CH || cur_phase == PH_CL || cur_phase == PH_T2))
		|=> $stable(crc_q))
		else $error("crc changed while emitting trailer bytes");

	// the entry is released only after its data byte or the trailer
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cur_phase == PH_DATA || cur_phase == PH_T2 || cur_phase == PH_CR))
		else $error("queue entry released mid frame");

endmodule

`default_nettype wire

[hdl/crc16_framed_response_encoder.sv]
`default_nettype none

// an accepted item is queued, and its first result byte leaves through the output register
// throughput: one output byte per cycle from the frame sequencer while an entry is queued
// and the output is free; first bytes get a header, last bytes a crc and trailer
// the input side keeps taking items while the queue (QUEUE_DEPTH entries) has room
// reset: append_return is 1, crc is 0xffff, no frame open, queue and output empty
module crc16_framed_response_encoder #(
	parameter int QUEUE_DEPTH = cfe_pkg::CFE_QUEUE_DEPTH
) (
	input  wire                          clk,
	input  wire                          arst_n,
	cfe_in_if.sink                       in_ch,
	cfe_out_if.source                    out_ch,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [cfe_pkg::CFE_ADDR_W-1:0] paddr,
	input  wire [31:0]                   pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import cfe_pkg::*;

	logic        append_return_q;
	logic        cfg_wr;
	logic        push;
	logic        pop;
	cfe_entry_t  push_entry;
	cfe_entry_t  head;
	cfe_q_stat_t stat;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			append_return_q <= 1'b1;
		end else if (cfg_wr && paddr == CFE_REG_APPEND_RETURN) begin
			append_return_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == CFE_REG_APPEND_RETURN) begin
			prdata = {31'b0, append_return_q};
		end
	end

	// intake and classification
	cfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.stat       (stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	cfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (stat)
	);

	// frame sequencer and crc
	cfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.stat          (stat),
		.append_return (append_return_q),
		.pop           (pop),
		.out_ch        (out_ch)
	);

endmodule

`default_nettype wire
